// ===== hw/rtl/fbd_pkg.sv =====
package fbd_pkg;

    localparam int DIV_W  = 32;
    localparam int CNT_W  = 5;
    localparam int CLK_W  = 27;
    localparam int BAUD_W = 23;
    localparam int DL_W   = 16;
    localparam int FR_W   = 4;
    localparam int SUM_W  = 5;
    localparam int NUM_W  = 31;
    localparam int RATE_W = 28;

    localparam logic [CLK_W-1:0] CLK_RESET = 27'd100000000;
    localparam logic [FR_W-1:0]  MUL_FIRST = 4'd1;
    localparam logic [FR_W-1:0]  MUL_LAST  = 4'd15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_GO,
        S_BASE_WAIT,
        S_PREP,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_PREP2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } srch_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] divisor_latch;
        logic [FR_W-1:0] div_add;
        logic [FR_W-1:0] mul_val;
    } srch_res_t;

endpackage

// ===== hw/rtl/fractional_baud_divider_search.sv =====
// fractional baud divider search
// cfg channel (cfg_valid/cfg_ready, pclk_hz) sets the peripheral clock in hertz;
// cfg_ready is always high, write it only while no request is in flight
// in channel (in_valid/in_ready, baud_rate) takes one requested rate per word;
// out channel (out_valid/out_ready) returns divisor_latch, div_add, mul_val
// one request is worked at a time on a single bit-serial divider; a zero
// rate answers without a division, an exact clock divide after one, and a
// full search of the 120 (div_add, mul_val) pairs runs two divisions per pair
// the search stops at the first pair that hits the rate exactly
// the result sits in an output register, so a new word is taken while the
// previous answer waits on a stalled out_ready; the search only holds its
// answer if that register is still full and stalled when it finishes
// reset returns pclk_hz to 100000000, empties the output and idles the search
module fractional_baud_divider_search
    import fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  pclk_hz,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BAUD_W-1:0] baud_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DL_W-1:0]   divisor_latch,
    output logic [FR_W-1:0]   div_add,
    output logic [FR_W-1:0]   mul_val
);

    logic [CLK_W-1:0] pclk_reg;
    logic             out_valid_reg, out_valid_next;
    logic [DL_W-1:0]  dl_reg;
    logic [FR_W-1:0]  add_reg;
    logic [FR_W-1:0]  mul_reg;

    logic             idle;
    logic             res_ack;
    srch_res_t        res;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pclk_reg <= CLK_RESET;
        else if (cfg_valid)
            pclk_reg <= pclk_hz;
    end

    fbd_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid),
        .baud    (baud_rate),
        .pclk    (pclk_reg),
        .idle    (idle),
        .res     (res),
        .res_ack (res_ack),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    fbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register frees up in the same cycle it is taken
    always_comb
    begin
        res_ack        = res.valid && (!out_valid_reg || out_ready);
        out_valid_next = out_valid_reg;
        if (res_ack)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            dl_reg  <= res.divisor_latch;
            add_reg <= res.div_add;
            mul_reg <= res.mul_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign divisor_latch = dl_reg;
    assign div_add       = add_reg;
    assign mul_val       = mul_reg;

endmodule

// ===== hw/rtl/fbd_div.sv =====
module fbd_div
    import fbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        fits      = ~diff[DIV_W];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/fbd_search.sv =====
module fbd_search
    import fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BAUD_W-1:0] baud,
    input  logic [CLK_W-1:0]  pclk,
    output logic              idle,
    output srch_res_t         res,
    input  logic              res_ack,
    output div_req_t          div_req,
    input  div_rsp_t          div_rsp
);

    srch_state_t       state_reg, state_next;
    logic [BAUD_W-1:0] baud_reg, baud_next;
    logic [FR_W-1:0]   m_reg, m_next;
    logic [FR_W-1:0]   a_reg, a_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  den_reg, den_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic [DL_W-1:0]   best_dl_reg, best_dl_next;
    logic [FR_W-1:0]   best_add_reg, best_add_next;
    logic [FR_W-1:0]   best_mul_reg, best_mul_next;
    logic [BAUD_W-1:0] best_err_reg, best_err_next;

    logic [SUM_W-1:0]  cand_sum;
    logic [DIV_W:0]    q_inc;
    logic [DL_W-1:0]   dl_raw;
    logic [RATE_W:0]   rate_inc;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] baud_ext;
    logic [RATE_W-1:0] err;
    logic              better;
    logic              last_pair;

    always_comb
    begin
        cand_sum  = SUM_W'(a_reg) + SUM_W'(m_reg);
        q_inc     = {1'b0, div_rsp.quotient} + 1'b1;
        dl_raw    = q_inc[DL_W:1];
        rate_inc  = {1'b0, div_rsp.quotient[RATE_W-1:0]} + 1'b1;
        rate      = rate_inc[RATE_W:1];
        baud_ext  = RATE_W'(baud_reg);
        err       = (rate >= baud_ext) ? (rate - baud_ext) : (baud_ext - rate);
        better    = err < RATE_W'(best_err_reg);
        last_pair = (m_reg == MUL_LAST) && ((a_reg + 1'b1) == m_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        baud_next         = baud_reg;
        m_next            = m_reg;
        a_next            = a_reg;
        sum_next          = sum_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        dl_next           = dl_reg;
        best_dl_next      = best_dl_reg;
        best_add_next     = best_add_reg;
        best_mul_next     = best_mul_reg;
        best_err_next     = best_err_reg;
        idle              = 1'b0;
        res.valid         = 1'b0;
        res.divisor_latch = best_dl_reg;
        res.div_add       = best_add_reg;
        res.mul_val       = best_mul_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = DIV_W'(num_reg);
        div_req.divisor   = DIV_W'(den_reg);

        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    baud_next     = baud;
                    best_dl_next  = '0;
                    best_add_next = '0;
                    best_mul_next = MUL_FIRST;
                    state_next    = (baud == '0) ? S_DONE : S_BASE_GO;
                end
            end
            S_BASE_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(pclk);
                div_req.divisor  = DIV_W'({baud_reg, 4'b0000});
                state_next       = S_BASE_WAIT;
            end
            S_BASE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    best_dl_next = div_rsp.quotient[DL_W-1:0];
                    if (div_rsp.remainder == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        best_err_next = baud_reg;
                        m_next        = MUL_FIRST;
                        a_next        = '0;
                        state_next    = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                sum_next   = cand_sum;
                num_next   = NUM_W'(m_reg) * NUM_W'(pclk);
                den_next   = (NUM_W'(baud_reg) * NUM_W'(cand_sum)) << 3;
                state_next = S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // latch is at least 1, at least 2 with a fractional add
                    if ((a_reg != '0) && (dl_raw < DL_W'(2)))
                        dl_next = DL_W'(2);
                    else if (dl_raw == '0)
                        dl_next = DL_W'(1);
                    else
                        dl_next = dl_raw;
                    state_next = S_PREP2;
                end
            end
            S_PREP2:
            begin
                den_next   = (NUM_W'(dl_reg) * NUM_W'(sum_reg)) << 3;
                state_next = S_DIV2_GO;
            end
            S_DIV2_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (better)
                    begin
                        best_err_next = err[BAUD_W-1:0];
                        best_dl_next  = dl_reg;
                        best_mul_next = m_reg;
                        best_add_next = a_reg;
                    end
                    if ((better && (err == '0)) || last_pair)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if ((a_reg + 1'b1) == m_reg)
                        begin
                            m_next = m_reg + 1'b1;
                            a_next = '0;
                        end
                        else
                        begin
                            a_next = a_reg + 1'b1;
                        end
                        state_next = S_PREP;
                    end
                end
            end
            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        baud_reg     <= baud_next;
        m_reg        <= m_next;
        a_reg        <= a_next;
        sum_reg      <= sum_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        dl_reg       <= dl_next;
        best_dl_reg  <= best_dl_next;
        best_add_reg <= best_add_next;
        best_mul_reg <= best_mul_next;
        best_err_reg <= best_err_next;
    end

endmodule

// ===== hw/rtl/fbd_checker.sv =====
module fbd_checker
    import fbd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CLK_W-1:0]  pclk_hz,
    input logic              in_valid,
    input logic              in_ready,
    input logic [BAUD_W-1:0] baud_rate,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DL_W-1:0]   divisor_latch,
    input logic [FR_W-1:0]   div_add,
    input logic [FR_W-1:0]   mul_val
);

    // a stalled word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(divisor_latch) && $stable(div_add) && $stable(mul_val))
        else $error("output word changed while stalled");

    // fractional pair is always a proper fraction
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mul_val != '0) && (div_add < mul_val))
        else $error("bad fractional pair");

    // a nonzero divide-add forces the latch to at least 2
    a_dl_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (div_add != '0) |-> (divisor_latch >= DL_W'(2)))
        else $error("latch below minimum with fractional add");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new word taken while a search runs");

endmodule

bind fractional_baud_divider_search fbd_checker u_fbd_checker (.*);

// ===== tb/baud_divider_checker.sv =====
module baud_divider_checker
    import fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CLK_W-1:0]  pclk_hz,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BAUD_W-1:0] baud_rate,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DL_W-1:0]   divisor_latch,
    input  logic [FR_W-1:0]   div_add,
    input  logic [FR_W-1:0]   mul_val,
    output int                fail_count,
    output int                pending,
    output int                results_seen
);

    typedef struct packed {
        logic [DL_W-1:0] latch;
        logic [FR_W-1:0] add;
        logic [FR_W-1:0] mul;
    } baud_setting_t;

    logic [CLK_W-1:0] clock_hz = CLK_RESET;
    baud_setting_t    expected_settings[$];

    // best divisor latch and fractional pair for one requested rate, 32-bit wrapping math
    function automatic baud_setting_t search_divider(input logic [CLK_W-1:0] clk_in,
                                                     input logic [BAUD_W-1:0] rate_in);
        int unsigned   fclk;
        int unsigned   rate;
        int unsigned   base;
        int unsigned   best_err;
        int unsigned   den;
        int unsigned   num;
        int unsigned   dl;
        int unsigned   est;
        int unsigned   err;
        int unsigned   m;
        int unsigned   a;
        bit            hit;
        baud_setting_t best;
        fclk       = clk_in;
        rate       = rate_in;
        best.latch = '0;
        best.add   = '0;
        best.mul   = MUL_FIRST;
        hit        = 1'b0;
        if (rate != 0)
        begin
            base       = 16 * rate;
            best.latch = DL_W'(fclk / base);
            if (fclk % base != 0)
            begin
                best_err = rate;
                for (m = 1; m < 16 && !hit; m++)
                begin
                    for (a = 0; a < m && !hit; a++)
                    begin
                        den = rate * (a + m);
                        num = 2 * m * fclk;
                        // keep the top bit clear when the doubled numerator fits
                        if (num[31])
                            dl = ((num / den) / 16 + 1) / 2;
                        else
                            dl = (((4 * m * fclk) / den) / 32 + 1) / 2;
                        dl = dl & 32'hFFFF;
                        if (dl == 0)
                            dl = 1;
                        if (a > 0 && dl < 2)
                            dl = 2;
                        est = ((fclk * m) / (dl * (a + m) * 8) + 1) / 2;
                        err = (est >= rate) ? est - rate : rate - est;
                        if (err < best_err)
                        begin
                            best_err   = err;
                            best.latch = DL_W'(dl);
                            best.add   = FR_W'(a);
                            best.mul   = FR_W'(m);
                            hit        = (err == 0);
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        baud_setting_t want;
        if (!rst_n)
        begin
            clock_hz     = CLK_RESET;
            fail_count   = 0;
            results_seen = 0;
            expected_settings.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_settings.push_back(search_divider(clock_hz, baud_rate));
            if (cfg_valid && cfg_ready)
                clock_hz = pclk_hz;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_settings.size() == 0)
                begin
                    $error("result word with nothing expected: divisor_latch %0d",
                           divisor_latch);
                    fail_count++;
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (divisor_latch !== want.latch)
                    begin
                        $error("divisor_latch expected %0d actual %0d", want.latch, divisor_latch);
                        fail_count++;
                    end
                    if (div_add !== want.add)
                    begin
                        $error("div_add expected %0d actual %0d", want.add, div_add);
                        fail_count++;
                    end
                    if (mul_val !== want.mul)
                    begin
                        $error("mul_val expected %0d actual %0d", want.mul, mul_val);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_settings.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import fbd_pkg::*;

    localparam int               RUN_LIMIT    = 10_000_000;
    localparam int               STALL_CYCLES = 20_000;
    localparam logic [CLK_W-1:0]  CLK_MAX     = '1;
    localparam logic [BAUD_W-1:0] BAUD_MAX    = '1;
    localparam int unsigned COMMON_RATES [12] = '{300, 1200, 2400, 9600, 19200, 38400,
                                                  57600, 115200, 230400, 921600, 1000000,
                                                  3000000};
    localparam int unsigned EDGE_RATES [9] = '{0, 1, 8388607, 115200, 9600, 6250,
                                               6250000, 8000000, 57600};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CLK_W-1:0]  pclk_hz;
    logic              in_valid;
    logic              in_ready;
    logic [BAUD_W-1:0] baud_rate;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DL_W-1:0]   divisor_latch;
    logic [FR_W-1:0]   div_add;
    logic [FR_W-1:0]   mul_val;

    int               fail_count;
    int               pending;
    int               results_seen;
    int               cycle_count  = 0;
    int               sent_count   = 0;
    int               clock_writes = 0;
    int               stall_left   = 0;
    logic             no_idle      = 1'b0;
    logic             stall_req    = 1'b0;
    logic             stall_done   = 1'b0;
    logic [CLK_W-1:0] clock_now    = CLK_RESET;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fractional_baud_divider_search u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .pclk_hz       (pclk_hz),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .baud_rate     (baud_rate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .divisor_latch (divisor_latch),
        .div_add       (div_add),
        .mul_val       (mul_val)
    );

    baud_divider_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .pclk_hz       (pclk_hz),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .baud_rate     (baud_rate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .divisor_latch (divisor_latch),
        .div_add       (div_add),
        .mul_val       (mul_val),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long stall on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_req && !stall_done)
        begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(99) >= 35);
    end

    function automatic logic [BAUD_W-1:0] pick_rate(input logic [CLK_W-1:0] hz);
        int unsigned roll;
        int unsigned cand;
        roll = $urandom_range(99);
        cand = $urandom_range(1, 8388607);
        if (roll < 35)
            cand = COMMON_RATES[$urandom_range(11)];
        else if (roll < 55)
            cand = $urandom_range(1, 4000);
        else if (roll < 70 && hz >= 16)
        begin
            // aim at a rate the clock divides exactly
            cand = hz / (16 * $urandom_range(1, 64));
            if (cand == 0 || hz % (16 * cand) != 0)
                cand = $urandom_range(1, 8388607);
        end
        else if (roll >= 97)
            cand = 0;
        return BAUD_W'(cand);
    endfunction

    task automatic send_baud(input logic [BAUD_W-1:0] rate);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        baud_rate <= rate;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sent_count++;
    endtask

    // hold the input until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_clock(input logic [CLK_W-1:0] hz);
        cfg_valid <= 1'b1;
        pclk_hz   <= hz;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        clock_now = hz;
        clock_writes++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        pclk_hz   = CLK_RESET;
        in_valid  = 1'b0;
        baud_rate = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset clock: zero rate, wrapped divisor, exact divides, rate above clock/16
        foreach (EDGE_RATES[i])
            send_baud(BAUD_W'(EDGE_RATES[i]));
        drain();
        // zero clock takes the exact path
        set_clock('0);
        send_baud('0);
        send_baud(BAUD_W'(1));
        send_baud(BAUD_MAX);
        drain();
        set_clock(CLK_MAX);
        send_baud(BAUD_W'(1));
        send_baud(BAUD_W'(9600));
        send_baud(BAUD_MAX);
        drain();
        // one hertz: no pair beats the rate itself
        set_clock(CLK_W'(1));
        send_baud(BAUD_W'(1));
        send_baud(BAUD_W'(2));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_clock(CLK_RESET);
                1: set_clock(CLK_W'($urandom_range(1000000, 134217727)));
                2: set_clock(CLK_W'(14745600));
                default: set_clock(CLK_W'($urandom_range(0, 134217727)));
            endcase
            no_idle <= (ph == 1);
            // long output stall while words keep arriving
            if (ph == 0)
                stall_req <= 1'b1;
            repeat (25)
                send_baud(pick_rate(clock_now));
            drain();
        end

        repeat (40) @(posedge clk);
        $display("covered %0d baud requests over %0d clock settings, %0d results checked",
                 sent_count, clock_writes + 1, results_seen);
        $display("including zero and full-scale rates and clocks, a long output stall ",
                 "and a full-speed stretch");
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== fractional_baud_divider_search.f =====
hw/rtl/fbd_pkg.sv
hw/rtl/fbd_div.sv
hw/rtl/fbd_search.sv
hw/rtl/fractional_baud_divider_search.sv
hw/rtl/fbd_checker.sv
tb/baud_divider_checker.sv
tb/testbench.sv
